// ===== hw/rtl/wacr_pkg.sv =====
// Package for the windowed average change reporter.
// Holds the transaction payload types, field widths and item kind codes.
// No dependencies.
package wacr_pkg;

    // Field widths of the sample and report transactions.
    localparam int TIME_W  = 31;
    localparam int DELTA_W = 32;
    localparam int MEAN_W  = 32;

    // Default number of frame-time deltas in the averaging window.
    localparam int DEFAULT_WINDOW_DEPTH = 16;

    // Item kind codes.
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // One input transaction: a frame-time sample or a warm-up restart.
    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] current_time;
        logic [TIME_W-1:0] previous_time;
    } sample_t;

    // One result transaction: a new rounded window mean.
    typedef struct packed {
        logic signed [MEAN_W-1:0] average_frame_time;
    } report_t;

endpackage

// ===== hw/rtl/wacr_channels.sv =====
// Valid/ready channel interfaces for the windowed average change reporter.
// Depends on wacr_pkg for the payload types.

// Channel that carries sample transactions into the block.
interface wacr_sample_if
    import wacr_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// Channel that carries report transactions out of the block.
interface wacr_report_if
    import wacr_pkg::*;
;
    logic    valid;
    logic    ready;
    report_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/windowed_average_change_reporter.sv =====
// Top level of the windowed average change reporter (boxcar mean of frame times).
// Depends on wacr_pkg and on the channel interfaces in wacr_channels.sv.
//
// Usage:
// - sample: valid/ready channel of sample_t. A transaction of kind KIND_SAMPLE
//   stores current_time - previous_time in a ring of WINDOW_DEPTH deltas and
//   updates a running total. A KIND_RESTART transaction only clears the
//   window-filled flag and never produces a report.
// - report: valid/ready channel of report_t. Once the write index has wrapped,
//   each sample yields the window mean rounded half away from zero; it is sent
//   only when it differs from the last mean sent, which it then replaces.
// - Throughput: one transaction per cycle, unless the output stalls. The
//   running total loop closes through total_reg; the division by the window
//   depth is a reciprocal multiply split into four pipelined partial products.
// - Path: an accepted sample passes s1 (add), s2 (magnitude), s3 (partial
//   products), s4 (sum) and the output register (compare) before its report.
// - Stalls: when report.ready is low the output register holds its report;
//   the pipeline keeps accepting until a stage with a pending report blocks,
//   and sample.ready falls only once every stage ahead is occupied.
// - Reset (rst_n low, asynchronous): index, running total, last mean and all
//   flags clear. The ring itself is not cleared; entries never written since
//   reset are masked as zero during the first pass, so no sweep is needed.
module windowed_average_change_reporter
    import wacr_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input logic           clk,
    input logic           rst_n,
    wacr_sample_if.sink   sample,
    wacr_report_if.source report
);

    // Derived widths and the reciprocal of twice the window depth.
    localparam int IDX_W   = $clog2(WINDOW_DEPTH);
    localparam int TOTAL_W = DELTA_W + $clog2(WINDOW_DEPTH);
    localparam int X_W     = TOTAL_W + 1;
    localparam int SHIFT   = X_W + $clog2(2 * WINDOW_DEPTH);
    localparam int M_W     = X_W + 2;
    localparam int HALF    = (M_W + 1) / 2;
    localparam int X_HI_W  = X_W - HALF;
    localparam int M_HI_W  = M_W - HALF;
    localparam int PROD_W  = X_W + M_W;

    localparam logic [63:0] DIVISOR   = 64'(2 * WINDOW_DEPTH);
    localparam logic [63:0] RECIP     = ((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR;
    localparam logic [M_W-1:0]    RECIP_M = RECIP[M_W-1:0];
    localparam logic [HALF-1:0]   M_LO    = RECIP_M[HALF-1:0];
    localparam logic [M_HI_W-1:0] M_HI    = RECIP_M[M_W-1:HALF];
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

    // Window state.
    logic signed [DELTA_W-1:0] ring [WINDOW_DEPTH];
    logic signed [DELTA_W-1:0] old_rd_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_step;
    logic [IDX_W-1:0]          rd_addr;
    logic                      filled_reg;
    logic                      primed_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [TOTAL_W-1:0] total_next;
    logic signed [MEAN_W-1:0]  last_avg_reg;

    // Pipeline stage registers.
    logic                      s1_valid_reg;
    logic signed [TOTAL_W-1:0] s1_total_reg;
    logic                      s2_valid_reg;
    logic                      s2_neg_reg;
    logic [X_W-1:0]            s2_x_reg;
    logic                      s3_valid_reg;
    logic                      s3_neg_reg;
    logic [2*HALF-1:0]         s3_ll_reg;
    logic [HALF+M_HI_W-1:0]    s3_lh_reg;
    logic [X_HI_W+HALF-1:0]    s3_hl_reg;
    logic [X_HI_W+M_HI_W-1:0]  s3_hh_reg;
    logic                      s4_valid_reg;
    logic signed [MEAN_W-1:0]  s4_mean_reg;
    logic                      rep_valid_reg;
    logic signed [MEAN_W-1:0]  rep_mean_reg;

    // Combinational signals.
    logic                      sample_accept;
    logic                      is_sample;
    logic                      wrap;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] old_delta;
    logic                      candidate;
    logic [TOTAL_W-1:0]        s1_mag;
    logic [X_W-1:0]            s2_x_next;
    logic [HALF-1:0]           x_lo;
    logic [X_HI_W-1:0]         x_hi;
    logic [PROD_W-1:0]         prod;
    logic [MEAN_W-1:0]         quot;
    logic signed [MEAN_W-1:0]  s4_mean_next;
    logic                      out_free;
    logic                      s4_differs;
    logic                      s4_go;
    logic                      rdy1;
    logic                      rdy2;
    logic                      rdy3;
    logic                      rdy4;

    // Handshake chain: a stage takes new data when it is empty or drains.
    assign out_free   = !rep_valid_reg || report.ready;
    assign s4_differs = (s4_mean_reg != last_avg_reg);
    assign s4_go      = s4_valid_reg && (!s4_differs || out_free);
    assign rdy4       = !s4_valid_reg || s4_go;
    assign rdy3       = !s3_valid_reg || rdy4;
    assign rdy2       = !s2_valid_reg || rdy3;
    assign rdy1       = !s1_valid_reg || rdy2;

    assign sample.ready  = rdy1;
    assign sample_accept = sample.valid && rdy1;
    assign is_sample     = (sample.payload.kind == KIND_SAMPLE);

    // Delta of this frame and the running total after the ring update.
    assign delta     = $signed({1'b0, sample.payload.current_time})
                     - $signed({1'b0, sample.payload.previous_time});
    assign old_delta = primed_reg ? old_rd_reg : '0;
    assign total_next = total_reg + TOTAL_W'(delta) - TOTAL_W'(old_delta);
    assign wrap      = (idx_reg == IDX_LAST);
    assign idx_step  = wrap ? '0 : idx_reg + IDX_W'(1);
    assign candidate = sample_accept && is_sample && (filled_reg || wrap);

    // Read address runs one slot ahead of the write, so the entry that the
    // next sample overwrites is already in old_rd_reg when it arrives.
    assign rd_addr = (sample_accept && is_sample) ? idx_step : idx_reg;

    // Delta ring memory.
    always_ff @(posedge clk)
    begin
        if (sample_accept && is_sample)
        begin
            ring[idx_reg] <= delta;
        end
        old_rd_reg <= ring[rd_addr];
    end

    // Window control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            filled_reg <= 1'b0;
            primed_reg <= 1'b0;
            total_reg  <= '0;
        end
        else if (sample_accept)
        begin
            if (is_sample)
            begin
                idx_reg   <= idx_step;
                total_reg <= total_next;
                if (wrap)
                begin
                    filled_reg <= 1'b1;
                    primed_reg <= 1'b1;
                end
            end
            else
            begin
                filled_reg <= 1'b0;
            end
        end
    end

    // Stage 2 input: sign and rounding numerator 2*|sum| + depth.
    assign s1_mag    = s1_total_reg[TOTAL_W-1] ? TOTAL_W'(-s1_total_reg)
                                               : TOTAL_W'(s1_total_reg);
    assign s2_x_next = {s1_mag, 1'b0} + X_W'(WINDOW_DEPTH);

    // Stage 3 input: halves of the numerator for the partial products.
    assign x_lo = s2_x_reg[HALF-1:0];
    assign x_hi = s2_x_reg[X_W-1:HALF];

    // Stage 4 input: sum of partial products, quotient and sign.
    assign prod = (PROD_W'(s3_hh_reg) << (2 * HALF))
                + ((PROD_W'(s3_lh_reg) + PROD_W'(s3_hl_reg)) << HALF)
                + PROD_W'(s3_ll_reg);
    assign quot = prod[SHIFT +: MEAN_W];
    assign s4_mean_next = s3_neg_reg ? -$signed(quot) : $signed(quot);

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= candidate;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_total_reg <= total_next;
        end
        if (rdy2)
        begin
            s2_neg_reg <= s1_total_reg[TOTAL_W-1];
            s2_x_reg   <= s2_x_next;
        end
        if (rdy3)
        begin
            s3_neg_reg <= s2_neg_reg;
            s3_ll_reg  <= (2 * HALF)'(x_lo) * (2 * HALF)'(M_LO);
            s3_lh_reg  <= (HALF + M_HI_W)'(x_lo) * (HALF + M_HI_W)'(M_HI);
            s3_hl_reg  <= (X_HI_W + HALF)'(x_hi) * (X_HI_W + HALF)'(M_LO);
            s3_hh_reg  <= (X_HI_W + M_HI_W)'(x_hi) * (X_HI_W + M_HI_W)'(M_HI);
        end
        if (rdy4)
        begin
            s4_mean_reg <= s4_mean_next;
        end
    end

    // Change detection and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_valid_reg <= 1'b0;
            last_avg_reg  <= '0;
        end
        else if (s4_go && s4_differs)
        begin
            rep_valid_reg <= 1'b1;
            last_avg_reg  <= s4_mean_reg;
        end
        else if (report.ready)
        begin
            rep_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_go && s4_differs)
        begin
            rep_mean_reg <= s4_mean_reg;
        end
    end

    assign report.valid                      = rep_valid_reg;
    assign report.payload.average_frame_time = rep_mean_reg;

    // A pending report always carries the mean that change detection stored.
    a_report_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid_reg |-> (rep_mean_reg == last_avg_reg))
        else $error("pending report differs from stored mean");

    // A restart transaction leaves the window unfilled.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && !is_sample) |=> !filled_reg)
        else $error("window still filled after restart");

    // The window can only be filled once the first pass has completed.
    a_filled_primed: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg |-> primed_reg)
        else $error("window filled before first pass completed");

    // The write index never leaves the ring.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
        else $error("write index out of range");

endmodule
